>>> rtl/tspc_pkg.sv
// Package for the triple-site pattern counter.
// Holds base codes, class and pair indexes, tally and result types.
// No dependencies.
package tspc_pkg;

	localparam int BASE_W        = 8;
	localparam int OUT_W         = 24;
	localparam int NUM_PATTERNS  = 5;
	localparam int NUM_PAIRS     = 3;
	localparam int COUNT_W_DEF   = 24;

	localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};

	localparam logic [BASE_W-1:0] BASE_A = 8'h41;
	localparam logic [BASE_W-1:0] BASE_C = 8'h43;
	localparam logic [BASE_W-1:0] BASE_G = 8'h47;
	localparam logic [BASE_W-1:0] BASE_T = 8'h54;

	localparam int PAT_ALL_SAME   = 0;
	localparam int PAT_FIRST_ODD  = 1;
	localparam int PAT_SECOND_ODD = 2;
	localparam int PAT_THIRD_ODD  = 3;
	localparam int PAT_ALL_DIFFER = 4;

	localparam int PAIR_AB = 0;
	localparam int PAIR_AC = 1;
	localparam int PAIR_BC = 2;

	typedef struct packed {
		logic [NUM_PATTERNS-1:0] pattern;
		logic [NUM_PAIRS-1:0]    match;
		logic [NUM_PAIRS-1:0]    mismatch;
	} tally_t;

	// first member lands in the highest bits
	typedef struct packed {
		logic [OUT_W-1:0] pair_bc_mismatch;
		logic [OUT_W-1:0] pair_bc_match;
		logic [OUT_W-1:0] pair_ac_mismatch;
		logic [OUT_W-1:0] pair_ac_match;
		logic [OUT_W-1:0] pair_ab_mismatch;
		logic [OUT_W-1:0] pair_ab_match;
		logic [OUT_W-1:0] all_differ_count;
		logic [OUT_W-1:0] third_odd_count;
		logic [OUT_W-1:0] second_odd_count;
		logic [OUT_W-1:0] first_odd_count;
		logic [OUT_W-1:0] all_same_count;
	} result_t;

	function automatic logic is_base(input logic [BASE_W-1:0] ch);
		return (ch == BASE_A) || (ch == BASE_C) || (ch == BASE_G) || (ch == BASE_T);
	endfunction

endpackage

>>> rtl/tspc_classify.sv
// Column classifier: decodes one registered column into counter increments.
// Depends on tspc_pkg.
module tspc_classify (
	input  logic [tspc_pkg::BASE_W-1:0] base_first,
	input  logic [tspc_pkg::BASE_W-1:0] base_second,
	input  logic [tspc_pkg::BASE_W-1:0] base_third,
	output tspc_pkg::tally_t            tally
);
	import tspc_pkg::*;

	logic va, vb, vc, all_valid;
	logic eq_ab, eq_ac, eq_bc;

	always_comb begin
		va        = is_base(base_first);
		vb        = is_base(base_second);
		vc        = is_base(base_third);
		all_valid = va && vb && vc;
		eq_ab     = (base_first == base_second);
		eq_ac     = (base_first == base_third);
		eq_bc     = (base_second == base_third);

		tally.pattern[PAT_ALL_SAME]   = all_valid && eq_ab && eq_ac;
		tally.pattern[PAT_FIRST_ODD]  = all_valid && eq_bc && !eq_ab;
		tally.pattern[PAT_SECOND_ODD] = all_valid && eq_ac && !eq_bc;
		tally.pattern[PAT_THIRD_ODD]  = all_valid && eq_ab && !eq_bc;
		tally.pattern[PAT_ALL_DIFFER] = all_valid && !eq_ab && !eq_ac && !eq_bc;

		tally.match[PAIR_AB]    = va && vb && eq_ab;
		tally.mismatch[PAIR_AB] = va && vb && !eq_ab;
		tally.match[PAIR_AC]    = va && vc && eq_ac;
		tally.mismatch[PAIR_AC] = va && vc && !eq_ac;
		tally.match[PAIR_BC]    = vb && vc && eq_bc;
		tally.mismatch[PAIR_BC] = vb && vc && !eq_bc;
	end

endmodule

>>> rtl/tspc_counters.sv
// Saturating counter bank: pattern classes and pair match/mismatch.
// Gives the clipped post-update counts; clears on the last column.
// Depends on tspc_pkg.
module tspc_counters #(
	parameter int COUNT_WIDTH = tspc_pkg::COUNT_W_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  logic               last,
	input  tspc_pkg::tally_t   tally,
	output tspc_pkg::result_t  snapshot
);
	import tspc_pkg::*;

	localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

	logic [COUNT_WIDTH-1:0] pat_q   [NUM_PATTERNS];
	logic [COUNT_WIDTH-1:0] match_q [NUM_PAIRS];
	logic [COUNT_WIDTH-1:0] mis_q   [NUM_PAIRS];
	logic [COUNT_WIDTH-1:0] pat_nxt   [NUM_PATTERNS];
	logic [COUNT_WIDTH-1:0] match_nxt [NUM_PAIRS];
	logic [COUNT_WIDTH-1:0] mis_nxt   [NUM_PAIRS];

	function automatic logic [COUNT_WIDTH-1:0] bump(input logic [COUNT_WIDTH-1:0] v,
			input logic inc);
		return (inc && (v != CNT_MAX)) ? v + COUNT_WIDTH'(1) : v;
	endfunction

	function automatic logic [OUT_W-1:0] clip(input logic [COUNT_WIDTH-1:0] v);
		logic over;
		over = (COUNT_WIDTH > OUT_W) && (v > COUNT_WIDTH'(OUT_MAX));
		return over ? OUT_MAX : OUT_W'(v);
	endfunction

	always_comb begin
		for (int i = 0; i < NUM_PATTERNS; i++)
			pat_nxt[i] = bump(pat_q[i], tally.pattern[i]);
		for (int i = 0; i < NUM_PAIRS; i++) begin
			match_nxt[i] = bump(match_q[i], tally.match[i]);
			mis_nxt[i]   = bump(mis_q[i], tally.mismatch[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_PATTERNS; i++)
				pat_q[i] <= '0;
			for (int i = 0; i < NUM_PAIRS; i++) begin
				match_q[i] <= '0;
				mis_q[i]   <= '0;
			end
		end else if (step) begin
			for (int i = 0; i < NUM_PATTERNS; i++)
				pat_q[i] <= last ? '0 : pat_nxt[i];
			for (int i = 0; i < NUM_PAIRS; i++) begin
				match_q[i] <= last ? '0 : match_nxt[i];
				mis_q[i]   <= last ? '0 : mis_nxt[i];
			end
		end
	end

	always_comb begin
		snapshot.all_same_count   = clip(pat_nxt[PAT_ALL_SAME]);
		snapshot.first_odd_count  = clip(pat_nxt[PAT_FIRST_ODD]);
		snapshot.second_odd_count = clip(pat_nxt[PAT_SECOND_ODD]);
		snapshot.third_odd_count  = clip(pat_nxt[PAT_THIRD_ODD]);
		snapshot.all_differ_count = clip(pat_nxt[PAT_ALL_DIFFER]);
		snapshot.pair_ab_match    = clip(match_nxt[PAIR_AB]);
		snapshot.pair_ab_mismatch = clip(mis_nxt[PAIR_AB]);
		snapshot.pair_ac_match    = clip(match_nxt[PAIR_AC]);
		snapshot.pair_ac_mismatch = clip(mis_nxt[PAIR_AC]);
		snapshot.pair_bc_match    = clip(match_nxt[PAIR_BC]);
		snapshot.pair_bc_mismatch = clip(mis_nxt[PAIR_BC]);
	end

	a_clear_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		step && last |=> (pat_q[PAT_ALL_SAME] == '0) && (match_q[PAIR_AB] == '0)
			&& (mis_q[PAIR_BC] == '0))
		else $error("counters not cleared after last column");

endmodule

>>> rtl/triple_site_pattern_counter.sv
// Top level of the triple-site pattern counter: input register, classifier,
// counter bank and result register. Depends on tspc_pkg, tspc_classify, tspc_counters.
//
//  channel   | group    | contents
//  ----------+----------+----------------------------------------------------
//  columns   | s_axis   | tdata: three ASCII bases; tlast: last column
//  counts    | m_axis   | tdata: eleven 24-bit counts, one transfer per tlast
//
// One column per cycle unless a last column waits on a stalled result; the
// classifier and a saturating add sit between the input register and the counters.
// A last column's counts go through the input and then the result register to m_axis.
// A stalled result only blocks a following last column; other columns keep
// flowing into the counters.
// Reset clears all counters and both valid flags.
module triple_site_pattern_counter #(
	parameter int COUNT_WIDTH = tspc_pkg::COUNT_W_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // base_first, base_second, base_third
	input  logic        s_axis_tlast,   // last_site
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// all_same_count, first_odd_count, second_odd_count, third_odd_count,
	// all_differ_count, pair_ab_match, pair_ab_mismatch, pair_ac_match,
	// pair_ac_mismatch, pair_bc_match, pair_bc_mismatch
	output logic [263:0] m_axis_tdata
);
	import tspc_pkg::*;

	logic              valid_s1;
	logic              last_s1;
	logic [BASE_W-1:0] first_s1, second_s1, third_s1;
	logic              adv_s1;
	logic              out_valid_q;
	result_t           out_q;
	result_t           snapshot;
	tally_t            tally;

	assign adv_s1        = valid_s1 && (!last_s1 || !out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			first_s1  <= s_axis_tdata[7:0];
			second_s1 <= s_axis_tdata[15:8];
			third_s1  <= s_axis_tdata[23:16];
			last_s1   <= s_axis_tlast;
		end
	end

	tspc_classify u_classify (
		.base_first  (first_s1),
		.base_second (second_s1),
		.base_third  (third_s1),
		.tally       (tally)
	);

	tspc_counters #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_counters (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (adv_s1),
		.last     (last_s1),
		.tally    (tally),
		.snapshot (snapshot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && last_s1) begin
			out_q <= snapshot;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_q;

	a_result_follows_last: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && last_s1 |=> out_valid_q)
		else $error("last column did not produce a result");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && last_s1 |-> !out_valid_q || m_axis_tready)
		else $error("pending result overwritten");

	a_one_class: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> $onehot0(tally.pattern))
		else $error("column counted in more than one class");

	a_class_implies_pairs: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && (tally.pattern != '0) |-> ((tally.match | tally.mismatch) == '1))
		else $error("fully valid column missing a pair tally");

endmodule

>>> sim/tb.sv
// Self-checking bench for triple_site_pattern_counter: streams alignment columns,
// predicts the eleven site counts per alignment and checks every result transfer.
// Depends on tspc_pkg and the RTL top level only.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import tspc_pkg::*;

	localparam int CNT_W      = COUNT_W_DEF;
	localparam int IDLE_LIMIT = 2000;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [23:0]  s_axis_tdata;   // base_first, base_second, base_third
	logic         s_axis_tlast;   // last_site
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [263:0] m_axis_tdata;   // eleven counts, all_same_count lowest

	logic [CNT_W-1:0] pat_cnt   [NUM_PATTERNS];
	logic [CNT_W-1:0] pair_hit  [NUM_PAIRS];
	logic [CNT_W-1:0] pair_miss [NUM_PAIRS];
	result_t          pending_counts [$];

	int  mismatches = 0;
	int  idle_cycles = 0;
	int  hold_len = 0;
	bit  send_idle = 1'b1;
	bit  recv_idle = 1'b1;

	triple_site_pattern_counter #(
		.COUNT_WIDTH (CNT_W)
	) u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// ---------------------------------------------------------------- predictor
	function automatic logic valid_base(input logic [BASE_W-1:0] ch);
		case (ch)
			BASE_A, BASE_C, BASE_G, BASE_T: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		return (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
	endfunction

	function automatic logic [OUT_W-1:0] clip(input logic [CNT_W-1:0] v);
		if (v > OUT_MAX)
			return OUT_MAX;
		return OUT_W'(v);
	endfunction

	function automatic void clear_counts();
		for (int i = 0; i < NUM_PATTERNS; i++)
			pat_cnt[i] = '0;
		for (int i = 0; i < NUM_PAIRS; i++) begin
			pair_hit[i]  = '0;
			pair_miss[i] = '0;
		end
	endfunction

	function automatic void tally_pair(input int idx, input logic [7:0] x, input logic vx,
			input logic [7:0] y, input logic vy);
		if (vx && vy) begin
			if (x == y)
				pair_hit[idx] = sat_inc(pair_hit[idx]);
			else
				pair_miss[idx] = sat_inc(pair_miss[idx]);
		end
	endfunction

	function automatic void tally_column(input logic [7:0] a, input logic [7:0] b,
			input logic [7:0] c, input logic last);
		logic    va, vb, vc;
		int      cls;
		result_t counts;
		va = valid_base(a);
		vb = valid_base(b);
		vc = valid_base(c);
		if (va && vb && vc) begin
			if (a == b && a == c)
				cls = PAT_ALL_SAME;
			else if (b == c)
				cls = PAT_FIRST_ODD;
			else if (a == c)
				cls = PAT_SECOND_ODD;
			else if (a == b)
				cls = PAT_THIRD_ODD;
			else
				cls = PAT_ALL_DIFFER;
			pat_cnt[cls] = sat_inc(pat_cnt[cls]);
		end
		tally_pair(PAIR_AB, a, va, b, vb);
		tally_pair(PAIR_AC, a, va, c, vc);
		tally_pair(PAIR_BC, b, vb, c, vc);
		if (last) begin
			counts.all_same_count   = clip(pat_cnt[PAT_ALL_SAME]);
			counts.first_odd_count  = clip(pat_cnt[PAT_FIRST_ODD]);
			counts.second_odd_count = clip(pat_cnt[PAT_SECOND_ODD]);
			counts.third_odd_count  = clip(pat_cnt[PAT_THIRD_ODD]);
			counts.all_differ_count = clip(pat_cnt[PAT_ALL_DIFFER]);
			counts.pair_ab_match    = clip(pair_hit[PAIR_AB]);
			counts.pair_ab_mismatch = clip(pair_miss[PAIR_AB]);
			counts.pair_ac_match    = clip(pair_hit[PAIR_AC]);
			counts.pair_ac_mismatch = clip(pair_miss[PAIR_AC]);
			counts.pair_bc_match    = clip(pair_hit[PAIR_BC]);
			counts.pair_bc_mismatch = clip(pair_miss[PAIR_BC]);
			pending_counts = {pending_counts, counts};
			clear_counts();
		end
	endfunction

	// ---------------------------------------------------------------- checking
	task automatic report_error(input string msg);
		$display("[%0t] ERROR %s", $realtime, msg);
		mismatches++;
	endtask

	task automatic check_field(input string name, input logic [OUT_W-1:0] got,
			input logic [OUT_W-1:0] want);
		if (got !== want)
			report_error($sformatf("%s: got %0d expected %0d", name, got, want));
	endtask

	task automatic check_counts(input result_t got);
		result_t want;
		if (pending_counts.size() == 0) begin
			report_error("count transfer with no alignment pending");
		end else begin
			want = pending_counts.pop_front();
			check_field("all_same_count",   got.all_same_count,   want.all_same_count);
			check_field("first_odd_count",  got.first_odd_count,  want.first_odd_count);
			check_field("second_odd_count", got.second_odd_count, want.second_odd_count);
			check_field("third_odd_count",  got.third_odd_count,  want.third_odd_count);
			check_field("all_differ_count", got.all_differ_count, want.all_differ_count);
			check_field("pair_ab_match",    got.pair_ab_match,    want.pair_ab_match);
			check_field("pair_ab_mismatch", got.pair_ab_mismatch, want.pair_ab_mismatch);
			check_field("pair_ac_match",    got.pair_ac_match,    want.pair_ac_match);
			check_field("pair_ac_mismatch", got.pair_ac_mismatch, want.pair_ac_mismatch);
			check_field("pair_bc_match",    got.pair_bc_match,    want.pair_bc_match);
			check_field("pair_bc_mismatch", got.pair_bc_mismatch, want.pair_bc_mismatch);
		end
	endtask

	// results are checked before the same edge's column is tallied
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready)
				check_counts(result_t'(m_axis_tdata));
			if (s_axis_tvalid && s_axis_tready)
				tally_column(s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tdata[23:16],
					s_axis_tlast);
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// ---------------------------------------------------------------- receiver
	initial begin
		int gap;
		forever begin
			gap = recv_idle ? $urandom_range(0, 10) : 0;
			if (hold_len > 0) begin
				gap = hold_len;
				hold_len = 0;
			end
			if (gap > 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
			while (!m_axis_tvalid) @(posedge clk);
		end
	end

	// ---------------------------------------------------------------- sender
	task automatic send_column(input logic [7:0] a, input logic [7:0] b,
			input logic [7:0] c, input logic last);
		int gap;
		gap = send_idle ? $urandom_range(0, 10) : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {c, b, a};
		s_axis_tlast  <= last;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	task automatic wait_for_counts();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_counts.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic [7:0] pick_char();
		int r;
		r = $urandom_range(0, 99);
		case ($urandom_range(0, 3))
			0: pick_char = BASE_A;
			1: pick_char = BASE_C;
			2: pick_char = BASE_G;
			default: pick_char = BASE_T;
		endcase
		if (r >= 95)
			pick_char = 8'($urandom_range(0, 255));
		else if (r >= 90)
			pick_char = pick_char | 8'h20;
	endfunction

	// ---------------------------------------------------------------- tests
	task automatic test_directed();
		send_column(BASE_A, BASE_A, BASE_A, 1'b0);
		send_column(BASE_C, BASE_G, BASE_G, 1'b0);
		send_column(BASE_T, BASE_C, BASE_T, 1'b0);
		send_column(BASE_G, BASE_G, BASE_A, 1'b0);
		send_column(BASE_A, BASE_C, BASE_G, 1'b0);
		send_column(BASE_T, BASE_T, BASE_T, 1'b1);
		// no valid base anywhere: all-zero counts
		send_column(8'h00, 8'hff, 8'h6e, 1'b1);
		// invalid characters only knock out the pairs they touch
		send_column(BASE_A, 8'h78, BASE_A, 1'b0);
		send_column(8'h61, BASE_A, BASE_A, 1'b0);
		send_column(BASE_C, BASE_C, 8'hff, 1'b0);
		send_column(8'h40, 8'h42, 8'h55, 1'b0);
		send_column(8'hc1, 8'hc3, 8'hd4, 1'b0);
		send_column(8'h74, BASE_G, BASE_C, 1'b0);
		send_column(BASE_G, BASE_T, 8'h4e, 1'b1);
		// back-to-back last columns
		send_column(BASE_A, BASE_A, BASE_A, 1'b1);
		send_column(BASE_C, BASE_A, BASE_T, 1'b1);
		send_column(8'hff, 8'h00, 8'haa, 1'b1);
		wait_for_counts();
	endtask

	task automatic test_random_alignments(input int n_items);
		int         sent, run_len, i;
		logic [7:0] a, b, c;
		logic       last;
		sent = 0;
		while (sent < n_items) begin
			send_idle = ($urandom_range(0, 3) != 0);
			recv_idle = ($urandom_range(0, 3) != 0);
			run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
			for (i = 0; i < run_len; i++) begin
				a = pick_char();
				b = ($urandom_range(0, 2) == 0) ? a : pick_char();
				c = ($urandom_range(0, 2) == 0) ? (($urandom_range(0, 1) != 0) ? a : b) : pick_char();
				if (i == run_len - 1)
					last = ($urandom_range(0, 9) != 0);
				else
					last = ($urandom_range(0, 29) == 0);
				send_column(a, b, c, last);
			end
			sent += run_len;
			if ($urandom_range(0, 7) == 0)
				wait_for_counts();
		end
		wait_for_counts();
	endtask

	task automatic test_backpressure();
		int i;
		send_idle = 1'b0;
		recv_idle = 1'b0;
		hold_len  = 300;
		for (i = 0; i < 64; i++)
			send_column(pick_char(), pick_char(), pick_char(), (i % 4) == 3);
		wait_for_counts();
		send_idle = 1'b1;
		recv_idle = 1'b1;
	endtask

	initial begin
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tlast  <= 1'b0;
		clear_counts();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_backpressure();
		test_random_alignments(470);

		if (mismatches == 0 && pending_counts.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
